// ===== rtl/lud_pkg.sv =====
// Package for the lenient UTF-8 decoder: result types shared by the decode
// stage and the top level, and the byte scan functions of the decode stage.
// Depends on nothing.
package lud_pkg;

  localparam int unsigned CpWidth   = 21;
  localparam int unsigned QueueDepth = 4;

  typedef logic [CpWidth-1:0] cp_t;
  typedef logic [3:0][7:0]    byte4_t;

  typedef struct packed {
    cp_t  cp;
    logic run_last;
    logic string_end;
  } result_t;

  typedef struct packed {
    logic [1:0]         n;
    result_t [2:0]      res;
  } bundle_t;

  // Sequence length started by byte c: 2, 3 or 4 for a lead, else 1.
  function automatic logic [2:0] seq_len(logic [7:0] c);
    logic [2:0] len;
    if (c < 8'h80)                    len = 3'd1;
    else if ((c & 8'hE0) == 8'hC0)    len = 3'd2;
    else if ((c & 8'hF0) == 8'hE0)    len = 3'd3;
    else if ((c & 8'hF8) == 8'hF0)    len = 3'd4;
    else                              len = 3'd1;
    return len;
  endfunction

  // Join lead payload bits and the low six bits of each following byte.
  function automatic cp_t join_seq(byte4_t src, logic [2:0] len);
    cp_t cp;
    if (len == 3'd2)      cp = cp_t'(src[0] & 8'h1F);
    else if (len == 3'd3) cp = cp_t'(src[0] & 8'h0F);
    else                  cp = cp_t'(src[0] & 8'h07);
    for (int k = 1; k < 4; k++) begin
      if (3'(k) < len) cp = {cp[CpWidth-7:0], src[k][5:0]};
    end
    return cp;
  endfunction

  // Scan src[0..len) as a complete string; up to three results.
  function automatic bundle_t scan_to_end(byte4_t src, logic [2:0] len);
    bundle_t    r;
    logic [2:0] i;
    logic [2:0] need;
    logic [2:0] idx;
    logic [7:0] c;
    byte4_t     sub;
    r = '0;
    i = 3'd0;
    for (int s = 0; s < 3; s++) begin
      if (i < len) begin
        c    = src[i[1:0]];
        need = seq_len(c);
        for (int k = 0; k < 4; k++) begin
          idx    = i + 3'(k);
          sub[k] = src[idx[1:0]];
        end
        if (need > 3'd1 && ({1'b0, i} + {1'b0, need} <= {1'b0, len})) begin
          r.res[s].cp = join_seq(sub, need);
          i = i + need;
        end else begin
          r.res[s].cp = cp_t'(c);
          i = i + 3'd1;
        end
        r.n = 2'(s + 1);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/lud_if.sv =====
// Stream interfaces for the lenient UTF-8 decoder: byte words in, code
// point words out. Depends on lud_pkg.
interface lud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       final_byte;

  modport source (output valid, output byte_in, output final_byte, input ready);
  modport sink   (input valid, input byte_in, input final_byte, output ready);
endinterface

interface lud_out_if;
  logic          valid;
  logic          ready;
  lud_pkg::cp_t  code_point;
  logic          run_last;
  logic          string_end;

  modport source (output valid, output code_point, output run_last,
                  output string_end, input ready);
  modport sink   (input valid, input code_point, input run_last,
                  input string_end, output ready);
endinterface

// ===== rtl/lud_decode.sv =====
// Decode stage: holds the pending lead and continuation bytes and turns an
// accepted byte word into zero to three results. Depends on lud_pkg.
module lud_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       byte_in_i,
  input  logic             final_byte_i,
  output lud_pkg::bundle_t bundle_o
);
  import lud_pkg::*;

  logic [2:0][7:0] pend_q;
  logic [1:0]      cnt_q, cnt_d;
  logic            pend_we;
  logic [1:0]      pend_idx;
  byte4_t          buf_w;
  logic [2:0]      need;
  bundle_t         bun;
  logic [1:0]      last;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      buf_w[k] = (2'(k) < cnt_q && k < 3) ? pend_q[k[1:0]] : byte_in_i;
    end
  end

  always_comb begin
    bun      = '0;
    cnt_d    = cnt_q;
    pend_we  = 1'b0;
    pend_idx = cnt_q;
    need     = seq_len(pend_q[0]);
    last     = 2'd0;
    if (final_byte_i) begin
      bun   = scan_to_end(buf_w, {1'b0, cnt_q} + 3'd1);
      cnt_d = 2'd0;
    end else if (cnt_q == 2'd0) begin
      if (seq_len(byte_in_i) > 3'd1) begin
        pend_we = 1'b1;
        cnt_d   = 2'd1;
      end else begin
        bun.n         = 2'd1;
        bun.res[0].cp = cp_t'(byte_in_i);
      end
    end else if ({1'b0, cnt_q} + 3'd1 >= need) begin
      bun.n         = 2'd1;
      bun.res[0].cp = join_seq(buf_w, need);
      cnt_d         = 2'd0;
    end else begin
      pend_we = 1'b1;
      cnt_d   = cnt_q + 2'd1;
    end
    if (bun.n != 2'd0) begin
      last                     = bun.n - 2'd1;
      bun.res[last].run_last   = 1'b1;
      bun.res[last].string_end = final_byte_i;
    end
  end

  assign bundle_o = bun;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && pend_we) begin
      pend_q[pend_idx] <= byte_in_i;
    end
  end

endmodule

// ===== rtl/lenient_utf8_decoder.sv =====
// Top level of the lenient UTF-8 decoder: decode stage and result queue.
// Depends on lud_pkg, lud_if and lud_decode.
//
// Usage: byte words arrive on in_i, one per cycle, with final_byte set on
// the last byte of a string. Code point words leave on out_o; run_last marks
// the last result of one byte and string_end the last result of a string.
// A result is written to the queue as its byte is accepted. Bytes are taken
// one per cycle while the receiver keeps up; a byte that only starts or
// extends a multi-byte sequence gives no word. A final byte that closes a
// cut-short sequence gives up to three words, drained one per cycle from the
// four-entry result queue, and in_i.ready stays low while more than one
// word waits there. A stalled receiver holds the queue; one more byte is
// still taken while a single word waits. Reset empties the queue and drops
// any pending bytes.
module lenient_utf8_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  lud_in_if.sink     in_i,
  lud_out_if.source  out_o
);
  import lud_pkg::*;

  result_t [QueueDepth-1:0] q_q, q_d;
  logic [2:0]               cnt_q, cnt_d;
  logic                     push, pop;
  logic [2:0]               base;
  logic [2:0]               j;
  bundle_t                  bun;

  assign in_i.ready = (cnt_q <= 3'd1);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = out_o.valid && out_o.ready;

  lud_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (push),
    .byte_in_i    (in_i.byte_in),
    .final_byte_i (in_i.final_byte),
    .bundle_o     (bun)
  );

  always_comb begin
    base = cnt_q - {2'b0, pop};
    j    = 3'd0;
    for (int s = 0; s < QueueDepth; s++) begin
      // advance on pop
      if (pop && s < QueueDepth - 1) q_d[s] = q_q[2'(s + 1)];
      else                           q_d[s] = q_q[s];
      if (push && 3'(s) >= base) begin
        j = 3'(s) - base;
        if (j < {1'b0, bun.n}) q_d[s] = bun.res[j[1:0]];
      end
    end
    cnt_d = base + (push ? {1'b0, bun.n} : 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign out_o.valid      = (cnt_q != 3'd0);
  assign out_o.code_point = q_q[0].cp;
  assign out_o.run_last   = q_q[0].run_last;
  assign out_o.string_end = q_q[0].string_end;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for lenient_utf8_decoder: byte strings in, code point words out.
// Predicts every word from the string bytes and compares each field in order.
// Depends on lud_pkg, lud_if and the decoder top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lud_pkg::*;

  localparam int unsigned LimitCycles  = 200000;
  localparam int unsigned HoldCycles   = 60;
  localparam int unsigned SettleCycles = 8;

  localparam logic [7:0] AsciiTop   = 8'h80;
  localparam logic [7:0] Lead2Bits  = 8'hC0;
  localparam logic [7:0] Lead3Bits  = 8'hE0;
  localparam logic [7:0] Lead4Bits  = 8'hF0;
  localparam logic [7:0] Lead2Sel   = 8'hE0;
  localparam logic [7:0] Lead3Sel   = 8'hF0;
  localparam logic [7:0] Lead4Sel   = 8'hF8;
  localparam logic [7:0] Lead2Data  = 8'h1F;
  localparam logic [7:0] Lead3Data  = 8'h0F;
  localparam logic [7:0] Lead4Data  = 8'h07;
  localparam logic [7:0] TrailBits  = 8'h80;
  localparam logic [7:0] TrailData  = 8'h3F;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic sink_ready = 1'b0;

  lud_in_if  in_if ();
  lud_out_if out_if ();

  assign out_if.ready = sink_ready;

  lenient_utf8_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  result_t     pending_code_points[$];
  logic [7:0]  held_bytes[3];
  int unsigned held_count;
  logic [7:0]  str_bytes[$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_token;
  int unsigned hold_token_seen;
  int unsigned hold_left;
  int unsigned bytes_sent;
  int unsigned multi_word_ends;
  int unsigned code_points_seen;
  int unsigned errors;
  int unsigned cycles;

  function automatic int unsigned lead_length(logic [7:0] c);
    if (c < AsciiTop) return 1;
    if ((c & Lead2Sel) == Lead2Bits) return 2;
    if ((c & Lead3Sel) == Lead3Bits) return 3;
    if ((c & Lead4Sel) == Lead4Bits) return 4;
    return 1;
  endfunction

  function automatic cp_t pack_code_point(logic [3:0][7:0] s, int unsigned start,
                                          int unsigned len);
    logic [31:0] acc;
    if (len == 2) acc = 32'(s[start] & Lead2Data);
    else if (len == 3) acc = 32'(s[start] & Lead3Data);
    else acc = 32'(s[start] & Lead4Data);
    for (int unsigned k = 1; k < len; k++) begin
      acc = (acc << 6) | 32'(s[start + k] & TrailData);
    end
    return cp_t'(acc);
  endfunction

  // Work out the words caused by one accepted byte and queue them.
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic [3:0][7:0] seq;
    cp_t             cps[3];
    int unsigned     cnt;
    int unsigned     n;
    int unsigned     i;
    int unsigned     need;
    result_t         r;
    cnt = held_count;
    n   = 0;
    seq = '0;
    for (int unsigned k = 0; k < cnt; k++) seq[k] = held_bytes[k];
    seq[cnt] = b;
    if (fin) begin
      i = 0;
      while (i <= cnt && n < 3) begin
        need = lead_length(seq[i]);
        if (need > 1 && i + need <= cnt + 1) begin
          cps[n] = pack_code_point(seq, i, need);
          i += need;
        end else begin
          cps[n] = cp_t'(seq[i]);
          i += 1;
        end
        n++;
      end
      held_count = 0;
    end else if (cnt == 0) begin
      if (lead_length(b) > 1) begin
        held_bytes[0] = b;
        held_count    = 1;
      end else begin
        cps[0] = cp_t'(b);
        n      = 1;
      end
    end else begin
      need = lead_length(seq[0]);
      if (cnt + 1 >= need) begin
        cps[0]     = pack_code_point(seq, 0, need);
        n          = 1;
        held_count = 0;
      end else begin
        held_bytes[cnt] = b;
        held_count      = cnt + 1;
      end
    end
    if (n > 1) multi_word_ends++;
    for (int unsigned k = 0; k < n; k++) begin
      r.cp         = cps[k];
      r.run_last   = (k == n - 1);
      r.string_end = fin && (k == n - 1);
      pending_code_points = {pending_code_points, r};
    end
  endtask

  // Offer one word and hold it until taken, then idle at random.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_if.valid      <= 1'b1;
    in_if.byte_in    <= b;
    in_if.final_byte <= fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    decode_byte(b, fin);
    bytes_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  task automatic send_string();
    for (int k = 0; k < str_bytes.size(); k++) begin
      send_byte(str_bytes[k], k == str_bytes.size() - 1);
    end
  endtask

  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    while (pending_code_points.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Append a well-formed character of len bytes, or only its first keep bytes.
  task automatic append_char(input int unsigned len, input int unsigned keep);
    logic [7:0] lead;
    case (len)
      1: lead = 8'($urandom_range(0, 127));
      2: lead = Lead2Bits | 8'($urandom_range(0, 31));
      3: lead = Lead3Bits | 8'($urandom_range(0, 15));
      default: lead = Lead4Bits | 8'($urandom_range(0, 7));
    endcase
    str_bytes = {str_bytes, lead};
    for (int unsigned k = 1; k < keep; k++) begin
      str_bytes = {str_bytes, TrailBits | 8'($urandom_range(0, 63))};
    end
  endtask

  task automatic build_random_string();
    int unsigned units;
    int unsigned len;
    str_bytes.delete();
    units = $urandom_range(1, 6);
    for (int unsigned u = 0; u < units; u++) begin
      if ($urandom_range(0, 99) < 75) begin
        len = $urandom_range(1, 4);
        append_char(len, len);
      end else begin
        str_bytes = {str_bytes, 8'($urandom_range(0, 255))};
      end
    end
    if ($urandom_range(0, 99) < 30) begin
      len = $urandom_range(2, 4);
      append_char(len, $urandom_range(1, len - 1));
      if ($urandom_range(0, 1) == 1) str_bytes = {str_bytes, 8'($urandom_range(0, 255))};
    end
  endtask

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    str_bytes = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                  8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hFF};
    send_string();
    str_bytes = '{8'hF7, 8'hBF, 8'hBF, 8'hBF};
    send_string();
    str_bytes = '{8'hF0, 8'h9F, 8'h98};
    send_string();
    str_bytes = '{8'hF0, 8'hC3, 8'hA9};
    send_string();
    str_bytes = '{8'hC3};
    send_string();
    wait_results_drained();
  endtask

  task automatic test_random_strings(input int unsigned idle, input int unsigned stall,
                                     input int unsigned count);
    int unsigned start;
    idle_pct  = idle;
    stall_pct = stall;
    start     = bytes_sent;
    while (bytes_sent - start < count) begin
      build_random_string();
      send_string();
    end
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    int unsigned start;
    idle_pct  = 0;
    stall_pct = 0;
    hold_token++;
    start = bytes_sent;
    while (bytes_sent - start < 30) begin
      build_random_string();
      send_string();
    end
    wait_results_drained();
  endtask

  always @(posedge clk_i) begin
    if (hold_token != hold_token_seen) begin
      hold_token_seen = hold_token;
      hold_left       = HoldCycles;
    end
    if (hold_left > 0) begin
      sink_ready <= 1'b0;
      hold_left--;
    end else begin
      sink_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      code_points_seen++;
      if (pending_code_points.size() == 0) begin
        $display("%0t: unexpected word cp=%h run_last=%b string_end=%b", $time,
                 out_if.code_point, out_if.run_last, out_if.string_end);
        errors++;
      end else begin
        want = pending_code_points.pop_front();
        if (out_if.code_point !== want.cp) begin
          $display("%0t: code_point expected %h got %h", $time, want.cp, out_if.code_point);
          errors++;
        end
        if (out_if.run_last !== want.run_last) begin
          $display("%0t: run_last expected %b got %b", $time, want.run_last, out_if.run_last);
          errors++;
        end
        if (out_if.string_end !== want.string_end) begin
          $display("%0t: string_end expected %b got %b", $time, want.string_end,
                   out_if.string_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    hold_token       = 0;
    hold_token_seen  = 0;
    hold_left        = 0;
    idle_pct         = 0;
    stall_pct        = 0;
    bytes_sent       = 0;
    multi_word_ends  = 0;
    code_points_seen = 0;
    errors           = 0;
    cycles           = 0;
    held_count       = 0;
    in_if.valid      = 1'b0;
    in_if.byte_in    = 8'h00;
    in_if.final_byte = 1'b0;
    rst_ni           = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_random_strings(0, 0, 75);
    test_random_strings(58, 0, 75);
    test_random_strings(0, 58, 75);
    test_random_strings(32, 32, 75);
    test_backpressure();

    $display("Sent %0d bytes, checked %0d code point words (%0d bytes gave several)",
             bytes_sent, code_points_seen, multi_word_ends);
    $display("Covered directed extremes, truncated endings, four idling mixes and a long stall");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
